// File: rtl/acbs_pkg.sv
// Shared types, widths and constants of the assist-control breath sequencer.
package acbs_pkg;

   // Minute length in milliseconds and the widths that follow from it
   localparam int MS_PER_MINUTE  = 60000;
   localparam int PERIOD_W       = $clog2(MS_PER_MINUTE + 1);
   localparam int RATE_W         = 6;
   localparam int INSP_W         = 14;
   localparam int PAUSE_W        = 13;
   localparam int TIMER_BITS_DEF = 16;

   // Streaming and register port widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 14;

   // Register indexes of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE  = 2'd0,
      CSR_RATE  = 2'd1,
      CSR_INSP  = 2'd2,
      CSR_PAUSE = 2'd3
   } csr_index_type;

   // Request kinds carried in tuser
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Breath states as reported on the result channel
   typedef enum logic [3:0] {
      SEQ_IDLE        = 4'd0,
      SEQ_INS_START   = 4'd1,
      SEQ_INS         = 4'd2,
      SEQ_PAUSE_START = 4'd3,
      SEQ_PAUSE       = 4'd4,
      SEQ_INS_DONE    = 4'd5,
      SEQ_EXP_START   = 4'd6,
      SEQ_EXP         = 4'd7,
      SEQ_EXP_DONE    = 4'd8
   } seq_code_type;

   // Phase codes
   localparam logic [1:0] PHASE_NONE = 2'd0;
   localparam logic [1:0] PHASE_INS  = 2'd1;
   localparam logic [1:0] PHASE_EXP  = 2'd2;

   // Commands from the control sequencer to the transition walker
   typedef struct packed {
      logic go;
      logic arm;
      logic cyc;
      logic trig;
      logic force_exp;
   } chain_ctrl_type;

   typedef struct packed {
      logic done;
   } chain_stat_type;

endpackage

// File: rtl/acbs_divider.sv
// Restoring divider: minute length over the breath rate, one quotient bit per cycle.
module acbs_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [acbs_pkg::RATE_W-1:0]         divisor,
   output logic                                done,
   output logic [acbs_pkg::PERIOD_W-1:0]       quotient
);

   localparam int QW = acbs_pkg::PERIOD_W;
   localparam int RW = acbs_pkg::RATE_W;
   localparam int CW = $clog2(QW + 1);

   logic [RW-1:0] div_ff, div_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW:0]   trial;
   logic          ge;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      trial = {rem_ff, quo_ff[QW-1]};
      ge    = (trial >= {1'b0, div_ff});
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = QW'(acbs_pkg::MS_PER_MINUTE);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? RW'(trial - {1'b0, div_ff}) : RW'(trial);
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/acbs_chain.sv
// Breath state walker: one state action per cycle through a shared timeout comparator.
module acbs_chain #(
   parameter int TIMER_BITS = acbs_pkg::TIMER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  acbs_pkg::chain_ctrl_type          ctrl,
   input  logic [acbs_pkg::INSP_W-1:0]       inspire_ms,
   input  logic [acbs_pkg::PAUSE_W-1:0]      pause_ms,
   input  logic [acbs_pkg::PERIOD_W-1:0]     expire_ms,
   output acbs_pkg::chain_stat_type          stat,
   output acbs_pkg::seq_code_type            seq_state,
   output logic [1:0]                        phase,
   output logic                              pulse_ins,
   output logic                              pulse_pause,
   output logic                              pulse_exp,
   output logic                              trig_kind
);

   localparam int CMP_W = (TIMER_BITS > acbs_pkg::PERIOD_W) ? TIMER_BITS
                                                           : acbs_pkg::PERIOD_W;
   localparam int NSEQ  = 9;

   typedef enum logic {
      CH_WAIT,
      CH_WALK
   } ch_state_type;

   // One-hot mark of a breath state in the visited set
   function automatic logic [NSEQ-1:0] seq_mark(input acbs_pkg::seq_code_type s);
      logic [NSEQ-1:0] m;
      m = '0;
      case (s)
         acbs_pkg::SEQ_IDLE:        m[0] = 1'b1;
         acbs_pkg::SEQ_INS_START:   m[1] = 1'b1;
         acbs_pkg::SEQ_INS:         m[2] = 1'b1;
         acbs_pkg::SEQ_PAUSE_START: m[3] = 1'b1;
         acbs_pkg::SEQ_PAUSE:       m[4] = 1'b1;
         acbs_pkg::SEQ_INS_DONE:    m[5] = 1'b1;
         acbs_pkg::SEQ_EXP_START:   m[6] = 1'b1;
         acbs_pkg::SEQ_EXP:         m[7] = 1'b1;
         acbs_pkg::SEQ_EXP_DONE:    m[8] = 1'b1;
         default:                   m    = '0;
      endcase
      return m;
   endfunction

   ch_state_type            st_ff, st_in;
   acbs_pkg::seq_code_type  seq_ff, seq_in;
   logic [TIMER_BITS-1:0]   timer_ff, timer_in;
   logic [1:0]              phase_ff, phase_in;
   logic                    kind_ff, kind_in;
   logic                    p_ins_ff, p_ins_in;
   logic                    p_pause_ff, p_pause_in;
   logic                    p_exp_ff, p_exp_in;
   logic                    cyc_ff, cyc_in;
   logic                    trig_ff, trig_in;
   logic [NSEQ-1:0]         visited_ff, visited_in;
   logic                    done_ff, done_in;
   logic [CMP_W-1:0]        dur;
   logic                    timeout;
   logic [NSEQ-1:0]         vis_now;

   // Shared comparator: phase timer against the duration of the current state
   always_comb begin
      case (seq_ff)
         acbs_pkg::SEQ_INS:   dur = CMP_W'(inspire_ms);
         acbs_pkg::SEQ_PAUSE: dur = CMP_W'(pause_ms);
         default:             dur = CMP_W'(expire_ms);
      endcase
      timeout = (CMP_W'(timer_ff) >= dur);
   end

   always_comb begin
      st_in      = st_ff;
      seq_in     = seq_ff;
      timer_in   = timer_ff;
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      p_ins_in   = p_ins_ff;
      p_pause_in = p_pause_ff;
      p_exp_in   = p_exp_ff;
      cyc_in     = cyc_ff;
      trig_in    = trig_ff;
      visited_in = visited_ff;
      done_in    = 1'b0;
      vis_now    = visited_ff | seq_mark(seq_ff);
      unique case (st_ff)
         CH_WAIT: begin
            if (ctrl.arm) begin
               // Start of a breath: arm inspiration, drop stale pulses
               seq_in     = acbs_pkg::SEQ_INS_START;
               p_ins_in   = 1'b0;
               p_pause_in = 1'b0;
               p_exp_in   = 1'b0;
            end else if (ctrl.go) begin
               // Millisecond tick: advance the timer, apply the force flag
               if (timer_ff != {TIMER_BITS{1'b1}}) begin
                  timer_in = timer_ff + TIMER_BITS'(1);
               end
               if (ctrl.force_exp && seq_ff != acbs_pkg::SEQ_IDLE &&
                   seq_ff != acbs_pkg::SEQ_EXP) begin
                  seq_in = acbs_pkg::SEQ_EXP_START;
               end
               cyc_in     = ctrl.cyc;
               trig_in    = ctrl.trig;
               visited_in = '0;
               p_ins_in   = 1'b0;
               p_pause_in = 1'b0;
               p_exp_in   = 1'b0;
               st_in      = CH_WALK;
            end
         end
         CH_WALK: begin
            // Run the action of the current state
            case (seq_ff)
               acbs_pkg::SEQ_INS_START: begin
                  timer_in = '0;
                  p_ins_in = 1'b1;
                  phase_in = acbs_pkg::PHASE_INS;
                  seq_in   = acbs_pkg::SEQ_INS;
               end
               acbs_pkg::SEQ_INS: begin
                  if (timeout) begin
                     seq_in = (pause_ms != '0) ? acbs_pkg::SEQ_PAUSE_START
                                               : acbs_pkg::SEQ_INS_DONE;
                  end else if (cyc_ff) begin
                     seq_in = acbs_pkg::SEQ_INS_DONE;
                  end
               end
               acbs_pkg::SEQ_PAUSE_START: begin
                  timer_in   = '0;
                  p_pause_in = 1'b1;
                  seq_in     = acbs_pkg::SEQ_PAUSE;
               end
               acbs_pkg::SEQ_PAUSE: begin
                  if (timeout) begin
                     seq_in = acbs_pkg::SEQ_INS_DONE;
                  end
               end
               acbs_pkg::SEQ_INS_DONE: begin
                  seq_in = acbs_pkg::SEQ_EXP_START;
               end
               acbs_pkg::SEQ_EXP_START: begin
                  timer_in = '0;
                  p_exp_in = 1'b1;
                  phase_in = acbs_pkg::PHASE_EXP;
                  seq_in   = acbs_pkg::SEQ_EXP;
               end
               acbs_pkg::SEQ_EXP: begin
                  if (timeout) begin
                     kind_in = 1'b0;
                     seq_in  = acbs_pkg::SEQ_EXP_DONE;
                  end else if (trig_ff) begin
                     kind_in = 1'b1;
                     seq_in  = acbs_pkg::SEQ_EXP_DONE;
                  end
               end
               acbs_pkg::SEQ_IDLE,
               acbs_pkg::SEQ_EXP_DONE: begin
                  seq_in = seq_ff;
               end
               default: begin
                  seq_in = acbs_pkg::SEQ_IDLE;
               end
            endcase
            visited_in = vis_now;
            // Stop once the chain returns to a state seen in this tick
            if ((vis_now & seq_mark(seq_in)) != '0) begin
               done_in = 1'b1;
               st_in   = CH_WAIT;
            end
         end
         default: st_in = CH_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= CH_WAIT;
         seq_ff     <= acbs_pkg::SEQ_IDLE;
         timer_ff   <= '0;
         phase_ff   <= acbs_pkg::PHASE_NONE;
         kind_ff    <= 1'b0;
         p_ins_ff   <= 1'b0;
         p_pause_ff <= 1'b0;
         p_exp_ff   <= 1'b0;
         done_ff    <= 1'b0;
         visited_ff <= '0;
      end else begin
         st_ff      <= st_in;
         seq_ff     <= seq_in;
         timer_ff   <= timer_in;
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         p_ins_ff   <= p_ins_in;
         p_pause_ff <= p_pause_in;
         p_exp_ff   <= p_exp_in;
         done_ff    <= done_in;
         visited_ff <= visited_in;
      end
      cyc_ff  <= cyc_in;
      trig_ff <= trig_in;
   end

   assign stat.done   = done_ff;
   assign seq_state   = seq_ff;
   assign phase       = phase_ff;
   assign pulse_ins   = p_ins_ff;
   assign pulse_pause = p_pause_ff;
   assign pulse_exp   = p_exp_ff;
   assign trig_kind   = kind_ff;

endmodule

// File: rtl/assist_control_breath_sequencer_top.sv
// Top level of the assist-control breath sequencer: ports, settings, control and result beat.
// Start beat: the result waits for the 16-step rate divider.
// Tick beat: the result waits for every state action chained in that millisecond.
// One request is in flight at a time; a new request is taken while the last result waits.
// Synchronous active-high reset: idle state, zero timers and phase, settings 0/12/1000/0.
module assist_control_breath_sequencer_top #(
   parameter int TIMER_BITS = acbs_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [acbs_pkg::REQ_DATA_W-1:0]     req_tdata,  // cycle_detected, trigger_detected,
                                                           // force_expiration, zero fill
   input  logic                                req_tuser,  // operation
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [acbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // state_code[3:0], phase[5:4],
                                                           // begin_inspiration, begin_pause,
                                                           // begin_expiration, cycle_end,
                                                           // next_trigger_kind, mode_echo,
                                                           // zero fill
   // configuration port
   input  logic                                csr_we,
   input  logic [acbs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [acbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHAIN,
      ST_DELIVER
   } ctl_state_type;

   localparam int PW = acbs_pkg::PERIOD_W;

   ctl_state_type                    st_ff, st_in;
   logic                             cfg_mode_ff;
   logic [acbs_pkg::RATE_W-1:0]      cfg_rate_ff;
   logic [acbs_pkg::INSP_W-1:0]      cfg_insp_ff;
   logic [acbs_pkg::PAUSE_W-1:0]     cfg_pause_ff;
   logic                             mode_ff, mode_in;
   logic [acbs_pkg::INSP_W-1:0]      insp_ff, insp_in;
   logic [acbs_pkg::PAUSE_W-1:0]     pause_ff, pause_in;
   logic [PW-1:0]                    expire_ff, expire_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [acbs_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                             accept;
   logic                             div_start;
   logic [acbs_pkg::RATE_W-1:0]      rate_eff;
   logic                             div_done;
   logic [PW-1:0]                    period;
   logic [PW-1:0]                    used;
   acbs_pkg::chain_ctrl_type         chain_ctrl;
   acbs_pkg::chain_stat_type         chain_stat;
   acbs_pkg::seq_code_type           seq_state;
   logic [1:0]                       phase;
   logic                             p_ins;
   logic                             p_pause;
   logic                             p_exp;
   logic                             trig_kind;
   logic                             cycle_end;

   // Hold the settings written through the register port
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff  <= 1'b0;
         cfg_rate_ff  <= acbs_pkg::RATE_W'(12);
         cfg_insp_ff  <= acbs_pkg::INSP_W'(1000);
         cfg_pause_ff <= '0;
      end else if (csr_we) begin
         unique case (acbs_pkg::csr_index_type'(csr_addr))
            acbs_pkg::CSR_MODE:  cfg_mode_ff  <= csr_wdata[0];
            acbs_pkg::CSR_RATE:  cfg_rate_ff  <= csr_wdata[acbs_pkg::RATE_W-1:0];
            acbs_pkg::CSR_INSP:  cfg_insp_ff  <= csr_wdata[acbs_pkg::INSP_W-1:0];
            acbs_pkg::CSR_PAUSE: cfg_pause_ff <= csr_wdata[acbs_pkg::PAUSE_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign div_start  = accept && (req_tuser == acbs_pkg::OP_START);
   assign rate_eff   = (cfg_rate_ff == '0) ? acbs_pkg::RATE_W'(1) : cfg_rate_ff;

   acbs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (rate_eff),
      .done     (div_done),
      .quotient (period)
   );

   // Tick commands go straight from the request beat; arm follows the divide
   always_comb begin
      chain_ctrl.go        = accept && (req_tuser == acbs_pkg::OP_TICK);
      chain_ctrl.arm       = (st_ff == ST_DIVIDE) && div_done;
      chain_ctrl.cyc       = req_tdata[0];
      chain_ctrl.trig      = req_tdata[1];
      chain_ctrl.force_exp = req_tdata[2];
   end

   acbs_chain #(
      .TIMER_BITS (TIMER_BITS)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (chain_ctrl),
      .inspire_ms  (insp_ff),
      .pause_ms    (pause_ff),
      .expire_ms   (expire_ff),
      .stat        (chain_stat),
      .seq_state   (seq_state),
      .phase       (phase),
      .pulse_ins   (p_ins),
      .pulse_pause (p_pause),
      .pulse_exp   (p_exp),
      .trig_kind   (trig_kind)
   );

   assign used      = PW'(insp_ff) + PW'(pause_ff);
   assign cycle_end = (seq_state == acbs_pkg::SEQ_EXP_DONE);

   // Control sequencer and result register
   always_comb begin
      st_in        = st_ff;
      mode_in      = mode_ff;
      insp_in      = insp_ff;
      pause_in     = pause_ff;
      expire_in    = expire_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == acbs_pkg::OP_START) begin
                  // Latch the breath settings; pause is dropped in pressure mode
                  mode_in  = cfg_mode_ff;
                  insp_in  = cfg_insp_ff;
                  pause_in = cfg_mode_ff ? '0 : cfg_pause_ff;
                  st_in    = ST_DIVIDE;
               end else begin
                  st_in = ST_CHAIN;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               expire_in = (period > used) ? PW'(period - used) : '0;
               st_in     = ST_DELIVER;
            end
         end
         ST_CHAIN: begin
            if (chain_stat.done) begin
               st_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, mode_ff, cycle_end & trig_kind, cycle_end,
                               p_exp, p_pause, p_ins, phase, seq_state};
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         mode_ff      <= 1'b0;
         insp_ff      <= '0;
         pause_ff     <= '0;
         expire_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         mode_ff      <= mode_in;
         insp_ff      <= insp_in;
         pause_ff     <= pause_in;
         expire_ff    <= expire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The walker finishes only while the sequencer waits for it
   a_chain_done_in_chain: assert property (@(posedge clock) disable iff (reset)
      chain_stat.done |-> (st_ff == ST_CHAIN))
      else $error("chain finished outside the chain wait");

   // The divider finishes only while a start beat is being worked
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (st_ff == ST_DIVIDE))
      else $error("divider finished outside the divide wait");

   // A spontaneous mark is only reported at the end of a cycle
   a_kind_needs_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[10] || rsp_tdata[9]))
      else $error("trigger kind set without cycle end");

   // A start beat always reports the inspiration start state with no pulses
   a_start_result: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIVIDE && div_done) |=>
         (seq_state == acbs_pkg::SEQ_INS_START && !p_ins && !p_pause && !p_exp))
      else $error("start beat left wrong state or a stale pulse");

endmodule
